[sv/hhlp_pkg.sv]
// Shared types and byte constants for the HTTP header line parser.
`default_nettype none
package hhlp_pkg;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [15:0] MAX_VALUE_OFFSET_RESET = 16'd255;

  typedef enum logic [3:0] {
    ST_START  = 4'd0,
    ST_KEY    = 4'd1,
    ST_COLON  = 4'd2,
    ST_SPACE  = 4'd3,
    ST_VALUE  = 4'd4,
    ST_CR     = 4'd5,
    ST_LF     = 4'd6,
    ST_END_CR = 4'd7,
    ST_END_LF = 4'd8,
    ST_ERROR  = 4'd9
  } hhlp_state_e;

  typedef enum logic [3:0] {
    ROLE_SKIP    = 4'd0,
    ROLE_KEY     = 4'd1,
    ROLE_COLON   = 4'd2,
    ROLE_SPACE   = 4'd3,
    ROLE_VALUE   = 4'd4,
    ROLE_CR      = 4'd5,
    ROLE_LF      = 4'd6,
    ROLE_END_CR  = 4'd7,
    ROLE_END_LF  = 4'd8,
    ROLE_BODY    = 4'd9,
    ROLE_ERROR   = 4'd10
  } hhlp_role_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_request;
  } hhlp_in_t;

  typedef struct packed {
    hhlp_role_e  byte_role;
    logic        pair_done;
    logic [15:0] key_length;
    logic [15:0] value_length;
    logic        headers_done;
    logic        parse_error;
  } hhlp_out_t;

endpackage
`default_nettype wire

[sv/hhlp_in_stage.sv]
// Input register holding one byte item ahead of the parse step.
`default_nettype none
module hhlp_in_stage
  import hhlp_pkg::*;
(
  input  wire      clk_i,
  input  wire      rst_ni,
  input  wire      in_valid_i,
  output logic     in_ready_o,
  input  hhlp_in_t in_item_i,
  input  wire      advance_i,
  output logic     valid_o,
  output hhlp_in_t item_o
);

  logic     valid_q, valid_d;
  hhlp_in_t item_q;

  assign in_ready_o = !valid_q || advance_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

[sv/hhlp_core.sv]
// Line state machine and length counters; one byte is parsed per advance.
`default_nettype none
module hhlp_core
  import hhlp_pkg::*;
#(
  parameter int LENGTH_BITS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         advance_i,
  input  hhlp_in_t    item_i,
  input  wire  [15:0] max_value_offset_i,
  output hhlp_out_t   result_o
);

  localparam int CW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;
  localparam logic [CW-1:0] OUT_MAX = CW'(17'h0FFFF);

  hhlp_state_e            state_q, state_d, state_cur;
  logic [LENGTH_BITS-1:0] key_q, key_d, key_cur;
  logic [LENGTH_BITS-1:0] val_q, val_d, val_cur;
  logic [LENGTH_BITS-1:0] key_inc, val_inc;
  logic [CW-1:0]          key_ext, val_ext;
  logic                   err;
  hhlp_out_t              res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_START;
      key_q   <= '0;
      val_q   <= '0;
    end else if (advance_i) begin
      state_q <= state_d;
      key_q   <= key_d;
      val_q   <= val_d;
    end
  end

  always_comb begin
    logic [7:0] b;
    b         = item_i.data_byte;
    state_cur = item_i.start_of_request ? ST_START : state_q;
    key_cur   = item_i.start_of_request ? '0 : key_q;
    val_cur   = item_i.start_of_request ? '0 : val_q;
    key_inc   = (&key_cur) ? key_cur : key_cur + 1'b1;
    val_inc   = (&val_cur) ? val_cur : val_cur + 1'b1;
    key_ext   = CW'(key_cur);
    val_ext   = CW'(val_cur);

    state_d = state_cur;
    key_d   = key_cur;
    val_d   = val_cur;
    err     = 1'b0;
    res     = '0;
    res.byte_role = ROLE_ERROR;

    case (state_cur)
      ST_START: begin
        if (b == CHAR_CR || b == CHAR_LF) begin
          res.byte_role = ROLE_SKIP;
        end else begin
          state_d       = ST_KEY;
          key_d         = LENGTH_BITS'(1);
          res.byte_role = ROLE_KEY;
        end
      end
      ST_KEY: begin
        if (b == CHAR_COLON) begin
          if (key_cur == '0) begin
            err = 1'b1;
          end else begin
            state_d       = ST_COLON;
            res.byte_role = ROLE_COLON;
          end
        end else if (b == CHAR_CR || b == CHAR_LF) begin
          err = 1'b1;
        end else begin
          key_d         = key_inc;
          res.byte_role = ROLE_KEY;
        end
      end
      ST_COLON: begin
        if (b == CHAR_SPACE) begin
          state_d       = ST_SPACE;
          res.byte_role = ROLE_SPACE;
        end else begin
          err = 1'b1;
        end
      end
      ST_SPACE: begin
        state_d       = ST_VALUE;
        val_d         = LENGTH_BITS'(1);
        res.byte_role = ROLE_VALUE;
      end
      ST_VALUE: begin
        if (b == CHAR_CR) begin
          state_d       = ST_CR;
          res.byte_role = ROLE_CR;
        end else if (val_ext > CW'(max_value_offset_i)) begin
          err = 1'b1;
        end else begin
          val_d         = val_inc;
          res.byte_role = ROLE_VALUE;
        end
      end
      ST_CR: begin
        if (b == CHAR_LF) begin
          state_d          = ST_LF;
          res.byte_role    = ROLE_LF;
          res.pair_done    = 1'b1;
          res.key_length   = (key_ext > OUT_MAX) ? 16'hFFFF : key_ext[15:0];
          res.value_length = (val_ext > OUT_MAX) ? 16'hFFFF : val_ext[15:0];
        end else begin
          err = 1'b1;
        end
      end
      ST_LF: begin
        if (b == CHAR_CR) begin
          state_d       = ST_END_CR;
          res.byte_role = ROLE_END_CR;
        end else begin
          state_d       = ST_KEY;
          key_d         = LENGTH_BITS'(1);
          res.byte_role = ROLE_KEY;
        end
      end
      ST_END_CR: begin
        if (b == CHAR_LF) begin
          state_d          = ST_END_LF;
          res.byte_role    = ROLE_END_LF;
          res.headers_done = 1'b1;
        end else begin
          err = 1'b1;
        end
      end
      ST_END_LF: begin
        res.byte_role = ROLE_BODY;
      end
      default: begin
        state_d       = ST_ERROR;
        res.byte_role = ROLE_ERROR;
      end
    endcase

    if (err) begin
      state_d         = ST_ERROR;
      res             = '0;
      res.byte_role   = ROLE_ERROR;
      res.parse_error = 1'b1;
    end
  end

  assign result_o = res;

endmodule
`default_nettype wire

[sv/hhlp_out_stage.sv]
// Result register that holds one finished item until the consumer takes it.
`default_nettype none
module hhlp_out_stage
  import hhlp_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  input  hhlp_out_t result_i,
  output logic      advance_o,
  output logic      out_valid_o,
  input  wire       out_ready_i,
  output hhlp_out_t out_item_o
);

  logic      valid_q, valid_d;
  hhlp_out_t item_q;

  assign advance_o = in_valid_i && (!valid_q || out_ready_i);
  assign valid_d   = advance_o || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      item_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule
`default_nettype wire

[sv/http_header_line_parser_unit.sv]
// Top level of the byte-serial HTTP header line parser.
// Takes one header byte per item and returns one result item per byte, at a
// sustained rate of one item per cycle while out_ready_i stays high.
// Each item passes an input register, the state machine logic and a result
// register; both registers advance together while the result register is free
// or being drained. The user must write the value limit through cfg_we_i and
// cfg_wdata_i only while the block is idle; the block does not enforce this.
`default_nettype none
module http_header_line_parser_unit
  import hhlp_pkg::*;
#(
  parameter int LENGTH_BITS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  hhlp_in_t    in_item_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output hhlp_out_t   out_item_o,
  input  wire         cfg_we_i,
  input  wire  [15:0] cfg_wdata_i
);

  logic [15:0] max_off_q;
  logic        advance;
  logic        stage_valid;
  hhlp_in_t    stage_item;
  hhlp_out_t   result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_off_q <= MAX_VALUE_OFFSET_RESET;
    end else if (cfg_we_i) begin
      max_off_q <= cfg_wdata_i;
    end
  end

  hhlp_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  hhlp_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .advance_i          (advance),
    .item_i             (stage_item),
    .max_value_offset_i (max_off_q),
    .result_o           (result)
  );

  hhlp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (stage_valid),
    .result_i    (result),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire

[verif/hhlp_role_checker.sv]
// Checker for the header line parser: predicts each byte's role and compares the result items.
module hhlp_role_checker
  import hhlp_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  input  wire       in_ready_i,
  input  hhlp_in_t  in_item_i,
  input  wire       out_valid_i,
  input  wire       out_ready_i,
  input  hhlp_out_t out_item_i,
  input  wire       cfg_we_i,
  input  wire [15:0] cfg_wdata_i,
  output int        fail_count_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  hhlp_state_e line_st;
  logic [15:0] key_cnt;
  logic [15:0] val_cnt;
  logic [15:0] value_limit;

  hhlp_out_t expected_roles[$];
  int fails;
  int pending;
  int result_idx;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  function automatic logic [15:0] sat_inc16(logic [15:0] c);
    return (c == 16'hFFFF) ? c : c + 16'd1;
  endfunction

  function automatic hhlp_out_t decode_header_byte(hhlp_in_t it);
    hhlp_out_t  r;
    logic       err;
    logic [7:0] b;
    r = '0;
    r.byte_role = ROLE_ERROR;
    err = 1'b0;
    b = it.data_byte;
    if (it.start_of_request) begin
      line_st = ST_START;
      key_cnt = '0;
      val_cnt = '0;
    end
    case (line_st)
      ST_START: begin
        if (b == CHAR_CR || b == CHAR_LF) begin
          r.byte_role = ROLE_SKIP;
        end else begin
          line_st = ST_KEY;
          key_cnt = 16'd1;
          r.byte_role = ROLE_KEY;
        end
      end
      ST_KEY: begin
        if (b == CHAR_COLON) begin
          if (key_cnt == 0) begin
            err = 1'b1;
          end else begin
            line_st = ST_COLON;
            r.byte_role = ROLE_COLON;
          end
        end else if (b == CHAR_CR || b == CHAR_LF) begin
          err = 1'b1;
        end else begin
          key_cnt = sat_inc16(key_cnt);
          r.byte_role = ROLE_KEY;
        end
      end
      ST_COLON: begin
        if (b == CHAR_SPACE) begin
          line_st = ST_SPACE;
          r.byte_role = ROLE_SPACE;
        end else begin
          err = 1'b1;
        end
      end
      ST_SPACE: begin
        line_st = ST_VALUE;
        val_cnt = 16'd1;
        r.byte_role = ROLE_VALUE;
      end
      ST_VALUE: begin
        if (b == CHAR_CR) begin
          line_st = ST_CR;
          r.byte_role = ROLE_CR;
        end else if (val_cnt > value_limit) begin
          err = 1'b1;
        end else begin
          val_cnt = sat_inc16(val_cnt);
          r.byte_role = ROLE_VALUE;
        end
      end
      ST_CR: begin
        if (b == CHAR_LF) begin
          line_st = ST_LF;
          r.byte_role = ROLE_LF;
          r.pair_done = 1'b1;
          r.key_length = key_cnt;
          r.value_length = val_cnt;
        end else begin
          err = 1'b1;
        end
      end
      ST_LF: begin
        if (b == CHAR_CR) begin
          line_st = ST_END_CR;
          r.byte_role = ROLE_END_CR;
        end else begin
          line_st = ST_KEY;
          key_cnt = 16'd1;
          r.byte_role = ROLE_KEY;
        end
      end
      ST_END_CR: begin
        if (b == CHAR_LF) begin
          line_st = ST_END_LF;
          r.byte_role = ROLE_END_LF;
          r.headers_done = 1'b1;
        end else begin
          err = 1'b1;
        end
      end
      ST_END_LF: begin
        r.byte_role = ROLE_BODY;
      end
      default: begin
        line_st = ST_ERROR;
        r.byte_role = ROLE_ERROR;
      end
    endcase
    if (err) begin
      line_st = ST_ERROR;
      r.byte_role = ROLE_ERROR;
      r.parse_error = 1'b1;
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    fails++;
    $display("mismatch at result %0d: %s got %0d expected %0d", result_idx, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    hhlp_out_t want;
    if (!rst_ni) begin
      line_st = ST_START;
      key_cnt = '0;
      val_cnt = '0;
      value_limit = MAX_VALUE_OFFSET_RESET;
      expected_roles.delete();
      pending = 0;
      fails = 0;
      result_idx = 0;
    end else begin
      if (cfg_we_i) value_limit = cfg_wdata_i;
      if (in_valid_i && in_ready_i) expected_roles.push_back(decode_header_byte(in_item_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_roles.size() == 0) begin
          note_mismatch("unexpected item", 16'd0, 16'd0);
        end else begin
          want = expected_roles.pop_front();
          if (out_item_i.byte_role !== want.byte_role)
            note_mismatch("byte_role", 16'(out_item_i.byte_role), 16'(want.byte_role));
          if (out_item_i.pair_done !== want.pair_done)
            note_mismatch("pair_done", 16'(out_item_i.pair_done), 16'(want.pair_done));
          if (out_item_i.key_length !== want.key_length)
            note_mismatch("key_length", out_item_i.key_length, want.key_length);
          if (out_item_i.value_length !== want.value_length)
            note_mismatch("value_length", out_item_i.value_length, want.value_length);
          if (out_item_i.headers_done !== want.headers_done)
            note_mismatch("headers_done", 16'(out_item_i.headers_done), 16'(want.headers_done));
          if (out_item_i.parse_error !== want.parse_error)
            note_mismatch("parse_error", 16'(out_item_i.parse_error), 16'(want.parse_error));
        end
        result_idx++;
      end
      pending = expected_roles.size();
    end
  end

endmodule

[verif/tb.sv]
// Testbench top: drives header bytes and the value limit into the parser and gives the verdict.
module tb;
  import hhlp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int LONG_RUN     = 12;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  hhlp_in_t    in_item = '0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  hhlp_out_t   out_item;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  int fail_count;
  int pending;
  int sent_count = 0;
  int tx_idle_pct = 19;
  int rx_idle_pct = 68;
  int hold_seq = 0;
  int hold_seen = 0;
  int cycle_cnt = 0;

  http_header_line_parser_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  hhlp_role_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int held;
    forever begin
      @(posedge clk_i);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        out_ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk_i);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic sor);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item <= '{data_byte: b, start_of_request: sor};
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sent_count++;
  endtask

  // structural byte, now and then replaced by noise
  task automatic put_byte(input logic [7:0] b, input logic sor);
    if ($urandom_range(0, 99) < 2) b = 8'($urandom_range(0, 255));
    send_byte(b, sor);
  endtask

  task automatic send_run(input logic [7:0] b, input int n);
    repeat (n) send_byte(b, 1'b0);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_value_limit(input logic [15:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] key_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CHAR_CR || b == CHAR_LF || b == CHAR_COLON);
    return b;
  endfunction

  function automatic logic [7:0] value_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CHAR_CR);
    return b;
  endfunction

  task automatic send_request(input int span);
    int   nlines;
    int   klen;
    int   vlen;
    int   i;
    int   j;
    logic sor;
    logic [7:0] b;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(6, 16))
        send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 19) == 0));
      return;
    end
    sor = 1'b1;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        send_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF, sor);
        sor = 1'b0;
      end
    end
    nlines = $urandom_range(0, 4);
    for (i = 0; i < nlines; i++) begin
      klen = $urandom_range(1, 6);
      for (j = 0; j < klen; j++) begin
        if (i > 0 && j == 0 && $urandom_range(0, 7) == 0)
          b = $urandom_range(0, 1) ? CHAR_LF : CHAR_COLON;
        else
          b = key_char();
        put_byte(b, sor);
        sor = 1'b0;
      end
      put_byte(CHAR_COLON, 1'b0);
      put_byte(CHAR_SPACE, 1'b0);
      vlen = $urandom_range(1, span);
      if ($urandom_range(0, 7) == 0)
        b = $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
      else
        b = 8'($urandom_range(0, 255));
      send_byte(b, 1'b0);
      for (j = 1; j < vlen; j++) send_byte(value_char(), 1'b0);
      put_byte(CHAR_CR, 1'b0);
      put_byte(CHAR_LF, 1'b0);
    end
    put_byte(CHAR_CR, sor);
    put_byte(CHAR_LF, 1'b0);
    repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic run_random(input int target, input int span);
    int first;
    first = sent_count;
    while (sent_count - first < target) send_request(span);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // leading CR/LF skipped, first value byte CR, LF opening a key and colon closing it
    send_byte(CHAR_CR, 1'b1);
    send_byte(CHAR_LF, 1'b0);
    send_byte("A", 1'b0);
    send_byte(CHAR_COLON, 1'b0);
    send_byte(CHAR_SPACE, 1'b0);
    send_byte(CHAR_CR, 1'b0);
    send_byte("x", 1'b0);
    send_byte(CHAR_CR, 1'b0);
    send_byte(CHAR_LF, 1'b0);
    send_byte(CHAR_LF, 1'b0);
    send_byte(CHAR_COLON, 1'b0);
    send_byte(CHAR_SPACE, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CHAR_CR, 1'b0);
    send_byte(CHAR_LF, 1'b0);
    send_byte(CHAR_CR, 1'b0);
    send_byte(CHAR_LF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    // CR inside a key, sticky error, colon as first key byte, missing space
    send_byte("k", 1'b1);
    send_byte(CHAR_CR, 1'b0);
    send_byte("z", 1'b0);
    send_byte(CHAR_COLON, 1'b1);
    send_byte("a", 1'b0);
    send_byte(CHAR_COLON, 1'b0);
    send_byte("q", 1'b0);

    // zero limit: the second non-CR value byte faults
    write_value_limit(16'd0);
    send_byte("k", 1'b1);
    send_byte(CHAR_COLON, 1'b0);
    send_byte(CHAR_SPACE, 1'b0);
    send_byte("v", 1'b0);
    send_byte("w", 1'b0);

    write_value_limit(16'd4);
    hold_seq <= hold_seq + 1;
    run_random(150, 8);

    write_value_limit(16'd1);
    tx_idle_pct = 68;
    rx_idle_pct <= 19;
    hold_seq <= hold_seq + 1;
    run_random(140, 4);

    write_value_limit(16'd65534);
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    run_random(70, 12);
    // long key line
    send_byte("k", 1'b1);
    send_run("k", LONG_RUN);
    send_byte(CHAR_COLON, 1'b0);
    send_byte(CHAR_SPACE, 1'b0);
    send_byte("v", 1'b0);
    send_byte(CHAR_CR, 1'b0);
    send_byte(CHAR_LF, 1'b0);
    send_byte(CHAR_CR, 1'b0);
    send_byte(CHAR_LF, 1'b0);
    // long value under a limit of 65534
    send_byte("k", 1'b1);
    send_byte(CHAR_COLON, 1'b0);
    send_byte(CHAR_SPACE, 1'b0);
    send_run("v", 20);

    // all-ones limit: long value without a fault
    write_value_limit(16'hFFFF);
    send_byte("k", 1'b1);
    send_byte(CHAR_COLON, 1'b0);
    send_byte(CHAR_SPACE, 1'b0);
    send_run("v", LONG_RUN);
    send_byte(CHAR_CR, 1'b0);
    send_byte(CHAR_LF, 1'b0);

    write_value_limit(16'($urandom_range(2, 30)));
    run_random(60, 24);

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
